// File: sv/eipd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Exact integer point distance: shared definitions
// Widths, status codes and rounding mode codes used by the interfaces and
// the core.
// ----------------------------------------------------------------------------
package eipd_pkg;

  // Coordinates are taken from their low COORD_BITS bits, sign extended.
  localparam int COORD_BITS     = 32;
  localparam int COORD_W        = 32;               // port width of a coordinate
  localparam int DIFF_W         = COORD_BITS + 1;   // exact coordinate difference
  localparam int ABS_W          = 32;               // magnitude of a difference
  localparam int SQ_W           = 64;               // square and root operand
  localparam int SUM_W          = SQ_W + 1;         // sum of two squares
  localparam int SQRT_TOP_SHIFT = 62;
  localparam int SQRT_STEPS     = SQRT_TOP_SHIFT / 2 + 1;
  localparam int ROOT_W         = SQ_W / 2;
  localparam int DIST_W         = ROOT_W + 1;
  localparam int MODE_W         = 2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_BAD_MODE = 2'd2
  } status_t;

  localparam logic [MODE_W-1:0] MODE_NEAREST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CEIL    = 2'd1;

endpackage : eipd_pkg
`default_nettype wire

// File: sv/eipd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Exact integer point distance: channel interfaces
// A point pair word going in and a distance word coming out, each with a
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface eipd_pair_if
  import eipd_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] first_x;
  logic signed [COORD_W-1:0] first_y;
  logic signed [COORD_W-1:0] second_x;
  logic signed [COORD_W-1:0] second_y;

  modport source (output valid, first_x, first_y, second_x, second_y, input ready);
  modport sink   (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface : eipd_pair_if

interface eipd_dist_if
  import eipd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  status_t           status;

  modport source (output valid, distance, status, input ready);
  modport sink   (input valid, distance, status, output ready);
endinterface : eipd_dist_if
`default_nettype wire

// File: sv/exact_integer_point_distance_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Exact integer point distance core
// Rounded Euclidean distance between two integer points, computed exactly
// with a restoring square root laid out as one pipeline stage per root bit.
// ----------------------------------------------------------------------------
// Pipeline: a distance word follows its pair word through 37 registers
// (difference, magnitude, square, sum, 32 root stages and the
// rounding/output register).
// Throughput: one word per cycle while the output is not stalled; the 32 root stages each hold one item.
// Reset: synchronous rst empties every pipeline stage and sets the rounding
// mode to nearest.
module exact_integer_point_distance_core
  import eipd_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_we,
  input  wire [MODE_W-1:0]    cfg_wdata,
  eipd_pair_if.sink           pair_in,
  eipd_dist_if.source         dist_out
);

  // Configuration register. The user must write it only while the pipeline is
  // empty (the block does not enforce this), so the output stage may read it directly.
  logic [MODE_W-1:0] rounding_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      rounding_mode <= MODE_NEAREST;
    end else if (cfg_we) begin
      rounding_mode <= cfg_wdata;
    end
  end

  // The whole pipeline moves as one. It advances whenever the output
  // register is empty or its word is being taken, so a stall at the output
  // freezes every stage together and nothing is lost or repeated.
  logic advance;
  assign advance       = !dist_out.valid || dist_out.ready;
  assign pair_in.ready = advance;

  // Stage 1: sign extend the low COORD_BITS bits of each coordinate and take
  // the exact differences. The differences are one bit wider than a
  // coordinate, so they never wrap.
  logic [DIFF_W-1:0] ext_fx, ext_fy, ext_sx, ext_sy;
  logic              v1;
  logic [DIFF_W-1:0] dx1, dy1;

  assign ext_fx = {pair_in.first_x[COORD_BITS-1],  pair_in.first_x[COORD_BITS-1:0]};
  assign ext_fy = {pair_in.first_y[COORD_BITS-1],  pair_in.first_y[COORD_BITS-1:0]};
  assign ext_sx = {pair_in.second_x[COORD_BITS-1], pair_in.second_x[COORD_BITS-1:0]};
  assign ext_sy = {pair_in.second_y[COORD_BITS-1], pair_in.second_y[COORD_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= pair_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dx1 <= ext_fx - ext_sx;
      dy1 <= ext_fy - ext_sy;
    end
  end

  // Stage 2: magnitudes. A magnitude is at most 2^COORD_BITS - 1, so its
  // low COORD_BITS bits hold it completely.
  logic [DIFF_W-1:0] neg_dx, neg_dy;
  logic              v2;
  logic [ABS_W-1:0]  ax2, ay2;

  assign neg_dx = '0 - dx1;
  assign neg_dy = '0 - dy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (advance) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ax2 <= dx1[DIFF_W-1] ? ABS_W'(neg_dx[COORD_BITS-1:0]) : ABS_W'(dx1[COORD_BITS-1:0]);
      ay2 <= dy1[DIFF_W-1] ? ABS_W'(neg_dy[COORD_BITS-1:0]) : ABS_W'(dy1[COORD_BITS-1:0]);
    end
  end

  // Stage 3: the two squares, one 32 by 32 multiplier each.
  logic            v3;
  logic [SQ_W-1:0] sx3, sy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (advance) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sx3 <= SQ_W'(ax2) * SQ_W'(ax2);
      sy3 <= SQ_W'(ay2) * SQ_W'(ay2);
    end
  end

  // Stage 4: the sum of squares. A carry out of 64 bits is an overflow; the
  // flag then rides along with the item through the root stages.
  logic [SUM_W-1:0] sum_sq;
  assign sum_sq = {1'b0, sx3} + {1'b0, sy3};

  // Root stages: index 0 is the sum register, index k holds the state after
  // k steps of the restoring method. rem_q is what is left of the operand,
  // res_q the partial root in its shifted form.
  logic            vld_q [0:SQRT_STEPS];
  logic            ovf_q [0:SQRT_STEPS];
  logic [SQ_W-1:0] rem_q [0:SQRT_STEPS];
  logic [SQ_W-1:0] res_q [0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q[0] <= 1'b0;
    end else if (advance) begin
      vld_q[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ovf_q[0] <= sum_sq[SQ_W];
      rem_q[0] <= sum_sq[SQ_W-1:0];
      res_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_root
    // The trial bit of this step: 4 to the power of (31 - k).
    localparam logic [SQ_W-1:0] TRIAL = SQ_W'(1) << (SQRT_TOP_SHIFT - 2 * k);

    logic [SQ_W-1:0] trial_sum;
    logic            fits;

    assign trial_sum = res_q[k] + TRIAL;
    assign fits      = rem_q[k] >= trial_sum;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k+1] <= 1'b0;
      end else if (advance) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        ovf_q[k+1] <= ovf_q[k];
        if (fits) begin
          rem_q[k+1] <= rem_q[k] - trial_sum;
          res_q[k+1] <= (res_q[k] >> 1) + TRIAL;
        end else begin
          rem_q[k+1] <= rem_q[k];
          res_q[k+1] <= res_q[k] >> 1;
        end
      end
    end
  end

  // Output stage: the final remainder is the sum less the square of the
  // floor root, so no second multiplication is needed. Rounding to nearest
  // goes up when the remainder exceeds the root (an exact half cannot occur
  // for integers, and the half-up rule reduces to this compare). Ceiling
  // goes up on any remainder at all.
  logic [ROOT_W-1:0] root;
  logic [SQ_W-1:0]   rem_final;
  logic              round_up;
  logic [DIST_W-1:0] dist_next;
  status_t           status_next;

  assign root      = res_q[SQRT_STEPS][ROOT_W-1:0];
  assign rem_final = rem_q[SQRT_STEPS];

  always_comb begin
    round_up    = 1'b0;
    dist_next   = '0;
    status_next = ST_OK;
    if (ovf_q[SQRT_STEPS]) begin
      // Overflow takes precedence over a bad mode.
      status_next = ST_OVERFLOW;
    end else if (rounding_mode != MODE_NEAREST && rounding_mode != MODE_CEIL) begin
      status_next = ST_BAD_MODE;
    end else begin
      if (rounding_mode == MODE_NEAREST) begin
        round_up = rem_final > SQ_W'(root);
      end else begin
        round_up = rem_final != '0;
      end
      dist_next = DIST_W'(root) + DIST_W'(round_up);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_out.valid <= 1'b0;
    end else if (advance) begin
      dist_out.valid <= vld_q[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dist_out.distance <= dist_next;
      dist_out.status   <= status_next;
    end
  end

endmodule : exact_integer_point_distance_core
`default_nettype wire
